// ===== design/deq_pkg.sv =====
package deq_pkg;

   // Store geometry.
   localparam int DEQ_CAPACITY = 16;
   localparam int WORD_BITS    = 32;
   localparam int IDX_BITS     = $clog2(DEQ_CAPACITY);
   localparam int COUNT_BITS   = $clog2(DEQ_CAPACITY + 1);

   // Operation codes carried in the request.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } deq_op_type;

   // Status codes carried in the response.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } deq_status_type;

   typedef struct packed {
      deq_op_type                   op;
      logic signed [WORD_BITS-1:0]  push_value;
   } deq_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0]  read_value;
      deq_status_type               status;
      logic                         is_empty;
      logic [COUNT_BITS-1:0]        fill_count;
   } deq_rsp_type;

   // Access to the entry store for one transaction.
   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [IDX_BITS-1:0]   addr;
      logic [WORD_BITS-1:0]  wdata;
   } deq_mem_cmd_type;

   // Result fields known when the transaction is accepted.
   typedef struct packed {
      deq_status_type         status;
      logic                   is_read;
      logic                   is_empty;
      logic [COUNT_BITS-1:0]  fill_count;
   } deq_meta_type;

endpackage

// ===== design/deq_ram.sv =====
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/deq_ctrl.sv =====
module deq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  deq_pkg::deq_req_type     req,
   output deq_pkg::deq_mem_cmd_type cmd,
   output deq_pkg::deq_meta_type    meta
);
   import deq_pkg::*;

   localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(DEQ_CAPACITY);
   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(DEQ_CAPACITY - 1);

   logic [IDX_BITS-1:0]   front_ff;
   logic [IDX_BITS-1:0]   front_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  full;
   logic                  empty;
   logic [IDX_BITS-1:0]   front_dec;
   logic [IDX_BITS-1:0]   front_inc;
   logic [IDX_BITS-1:0]   back_slot;
   logic [IDX_BITS-1:0]   tail_slot;

   // Index of the entry a given offset past the front, wrapped to the ring.
   function automatic logic [IDX_BITS-1:0] wrap_slot(
      input logic [IDX_BITS-1:0]   base,
      input logic [COUNT_BITS-1:0] offset
   );
      logic [COUNT_BITS:0] sum;
      logic [COUNT_BITS:0] folded;
      sum = {{(COUNT_BITS + 1 - IDX_BITS){1'b0}}, base} + {1'b0, offset};
      if (sum >= (COUNT_BITS + 1)'(DEQ_CAPACITY)) begin
         folded = sum - (COUNT_BITS + 1)'(DEQ_CAPACITY);
      end else begin
         folded = sum;
      end
      return folded[IDX_BITS-1:0];
   endfunction

   // Neighbor slots of the current ends.
   assign full      = (count_ff == CAP_COUNT);
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IDX_BITS'(1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_BITS'(1);
   assign back_slot = wrap_slot(front_ff, count_ff - COUNT_BITS'(1));
   assign tail_slot = wrap_slot(front_ff, count_ff);

   // Decode the operation into a store access and the next pointers.
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      cmd.wr_en     = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.addr      = front_ff;
      cmd.wdata     = req.push_value;
      meta.status   = ST_OK;
      meta.is_read  = 1'b0;
      unique case (req.op)
         OP_PUSH_FRONT: begin
            if (full) begin
               meta.status = ST_OVERFLOW;
            end else begin
               cmd.wr_en = 1'b1;
               cmd.addr  = front_dec;
               front_in  = front_dec;
               count_in  = count_ff + COUNT_BITS'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               meta.status = ST_OVERFLOW;
            end else begin
               cmd.wr_en = 1'b1;
               cmd.addr  = tail_slot;
               count_in  = count_ff + COUNT_BITS'(1);
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT: begin
            if (empty) begin
               meta.status = ST_UNDERFLOW;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr     = front_ff;
               meta.is_read = 1'b1;
               if (req.op == OP_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
         end
         OP_POP_BACK, OP_PEEK_BACK: begin
            if (empty) begin
               meta.status = ST_UNDERFLOW;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr     = back_slot;
               meta.is_read = 1'b1;
               if (req.op == OP_POP_BACK) begin
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase
      cmd.wr_en       = cmd.wr_en & accept;
      cmd.rd_en       = cmd.rd_en & accept;
      meta.fill_count = count_in;
      meta.is_empty   = (count_in == '0);
   end

   // Ring pointers advance only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count exceeds capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && (req.op == OP_PUSH_FRONT || req.op == OP_PUSH_BACK))
      |=> count_ff == $past(count_ff) + COUNT_BITS'(1))
      else $error("accepted push did not grow the count");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (accept && meta.status == ST_OVERFLOW) |-> full && !cmd.wr_en)
      else $error("overflow reported on a store that is not full");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !empty && !cmd.wr_en)
      else $error("store read issued on an empty deque");
`endif

endmodule

// ===== design/double_ended_queue.sv =====
// Bounded double-ended queue of signed words held in a ring buffer.
// Request channel (req_valid/req_ready/req_payload) carries an operation
// code and a push word: push or pop at the front or back, or peek at
// either end. Every request transaction yields exactly one response
// transaction (rsp_valid/rsp_ready/rsp_payload), in request order, with
// the word read, a status, an empty flag and the fill count after the step.
// Pop or peek on an empty deque reports underflow; push on a full deque
// reports overflow and drops the word. Neither changes the state.
// The response passes through the read stage and then the output register.
// Throughput: one transaction per cycle while responses are taken without
// stall; each operation makes a single access to the entry store, which has
// one write and one read port.
// Pointers are updated at acceptance, so back-to-back operations see each
// other's effects without forwarding.
// Reset empties the deque; the entry store itself is not cleared.
// A stalled response holds in the output register while one more
// transaction waits in the read stage; after that req_ready drops.
module double_ended_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  deq_pkg::deq_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_rsp_type rsp_payload
);
   import deq_pkg::*;

   logic            accept;
   logic            out_advance;
   deq_mem_cmd_type cmd;
   deq_meta_type    meta;
   logic [WORD_BITS-1:0] rd_data;
   logic            s1_valid_ff;
   deq_meta_type    s1_meta_ff;
   logic            rsp_valid_ff;
   deq_rsp_type     rsp_payload_ff;
   deq_rsp_type     rsp_payload_in;

   // Handshake: the read stage moves on whenever the output register frees.
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || out_advance;
   assign accept      = req_valid && req_ready;

   deq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cmd    (cmd),
      .meta   (meta)
   );

   deq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEQ_CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.addr),
      .wr_data (cmd.wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.addr),
      .rd_data (rd_data)
   );

   // Read stage: waits for the store data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (out_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
   end

   // Assemble the response from the stage fields and the read data.
   always_comb begin
      rsp_payload_in.read_value = s1_meta_ff.is_read ? rd_data : '0;
      rsp_payload_in.status     = s1_meta_ff.status;
      rsp_payload_in.is_empty   = s1_meta_ff.is_empty;
      rsp_payload_in.fill_count = s1_meta_ff.fill_count;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
